### src/icl_pkg.sv
// ----------------------------------------------------------------------------
// icl_pkg
// Shared types and constants of the indexed circular list engine: request
// codes, status codes, controller states and the fixed field widths.
// ----------------------------------------------------------------------------
package icl_pkg;

  // Default number of slots in the item store
  localparam int unsigned ICL_CAPACITY = 256;

  // Fixed payload widths
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned POS_W  = 9;
  localparam int unsigned ITEM_W = 64;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned LEN_W  = 9;

  // Request codes; the eighth code is unused and does nothing
  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT   = 3'd0,
    FN_REMOVE   = 3'd1,
    FN_READ     = 3'd2,
    FN_WRITE    = 3'd3,
    FN_ROT_FWD  = 3'd4,
    FN_ROT_BACK = 3'd5,
    FN_CLEAR    = 3'd6
  } func_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_GRAB,
    S_WALK,
    S_FINAL,
    S_DONE
  } state_e;

endpackage

### src/icl_store.sv
// ----------------------------------------------------------------------------
// icl_store
// Simple dual-port item memory: one write port, one read port with a
// registered read data output.
// ----------------------------------------------------------------------------
module icl_store
  import icl_pkg::*;
#(
  parameter int unsigned DEPTH = ICL_CAPACITY,
  parameter int unsigned AW    = $clog2(ICL_CAPACITY)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [ITEM_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [ITEM_W-1:0] rd_data_o
);

  logic [ITEM_W-1:0] mem [DEPTH];
  logic [ITEM_W-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### src/indexed_circular_list_engine.sv
// ----------------------------------------------------------------------------
// indexed_circular_list_engine
// Ordered list of up to CAPACITY signed 64-bit items in a circular store
// with a movable head slot.
// ----------------------------------------------------------------------------
// Usage:
//   A request (func, position, item_in) transfers on the input channel when
//   in_valid_i and in_ready_o are high; exactly one result (item_out, status,
//   length) follows on the output channel. One request is worked on at a
//   time; in_ready_o is high while the controller is idle.
//   Write, rotate, clear and any error finish in the setup state; read
//   also passes the grab state, remove passes grab and walk, and insert
//   passes walk and the final write of the new item, all then handing
//   over the result in the done state.
//   Insert and remove shift the later items one slot, one memory read and
//   one memory write per cycle through the single store.
//   Reset empties the list and sets the head slot to zero at once; the store
//   itself is not cleared, since only written slots are ever read.
//   A result that the receiver stalls sits in the output register; the next
//   request is accepted and worked on meanwhile, and waits only to hand
//   over its own result.
// ----------------------------------------------------------------------------
module indexed_circular_list_engine
  import icl_pkg::*;
#(
  parameter int unsigned CAPACITY = ICL_CAPACITY
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [FUNC_W-1:0]        func_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [ITEM_W-1:0] item_in_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [ITEM_W-1:0] item_out_o,
  output logic [STAT_W-1:0]        status_o,
  output logic [LEN_W-1:0]         length_o
);

  localparam int unsigned SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = (CW > POS_W) ? CW : POS_W;

  // Slot of list offset off: (h + off) mod CAPACITY, off never above CAPACITY
  function automatic logic [SW-1:0] slot_add(logic [SW-1:0] h, logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(h) + (CW+1)'(off);
    if (sum >= (CW+1)'(CAPACITY)) begin
      sum = sum - (CW+1)'(CAPACITY);
    end
    return sum[SW-1:0];
  endfunction

  function automatic logic [SW-1:0] slot_inc(logic [SW-1:0] s);
    return (s == SW'(CAPACITY - 1)) ? '0 : s + SW'(1);
  endfunction

  function automatic logic [SW-1:0] slot_dec(logic [SW-1:0] s);
    return (s == '0) ? SW'(CAPACITY - 1) : s - SW'(1);
  endfunction

  state_e state_q, state_d;

  // Control registers
  logic [SW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] left_q, left_d;
  logic          pend_q, pend_d;
  logic          out_valid_q, out_valid_d;

  // Payload registers
  func_e             func_q;
  logic [POS_W-1:0]  pos_q;
  logic [ITEM_W-1:0] item_q;
  logic [SW-1:0]     base_q, base_d;
  logic [SW-1:0]     src_q, src_d;
  logic [SW-1:0]     dst_q, dst_d;
  logic [SW-1:0]     pend_dst_q, pend_dst_d;
  logic [ITEM_W-1:0] result_q, result_d;
  status_e           stat_q, stat_d;
  logic [ITEM_W-1:0] item_out_q, item_out_d;
  status_e           status_q, status_d;
  logic [LEN_W-1:0]  length_q, length_d;

  // Memory port signals
  logic              wr_en;
  logic [SW-1:0]     wr_addr;
  logic [ITEM_W-1:0] wr_data;
  logic              rd_en;
  logic [SW-1:0]     rd_addr;
  logic [ITEM_W-1:0] rd_data;

  // Range checks against the current count
  logic [LW-1:0] pos_ext;
  logic [LW-1:0] cnt_ext;
  logic [CW-1:0] pos_cw;
  logic          ok_ins;
  logic          ok_pos;
  logic          full;
  logic          in_xfer;

  assign pos_ext = LW'(pos_q);
  assign cnt_ext = LW'(count_q);
  assign pos_cw  = pos_ext[CW-1:0];
  assign ok_ins  = (pos_ext <= cnt_ext);
  assign ok_pos  = (pos_ext < cnt_ext);
  assign full    = (count_q == CW'(CAPACITY));

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  icl_store #(
    .DEPTH (CAPACITY),
    .AW    (SW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Next state, memory accesses and register updates
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    left_d      = left_q;
    pend_d      = 1'b0;
    pend_dst_d  = pend_dst_q;
    base_d      = base_q;
    src_d       = src_q;
    dst_d       = dst_q;
    result_d    = result_q;
    stat_d      = stat_q;
    item_out_d  = item_out_q;
    status_d    = status_q;
    length_d    = length_q;
    out_valid_d = out_valid_q && !out_ready_i;
    wr_en       = 1'b0;
    wr_addr     = base_q;
    wr_data     = item_q;
    rd_en       = 1'b0;
    rd_addr     = base_q;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_SETUP;
        end
      end

      // Check the request, prepare the walk and do single-step operations
      S_SETUP: begin
        base_d   = slot_add(head_q, pos_cw);
        result_d = '0;
        stat_d   = ST_OK;
        state_d  = S_DONE;
        case (func_q)
          FN_INSERT: begin
            if (!ok_ins) begin
              stat_d = ST_RANGE;
            end else if (full) begin
              stat_d = ST_FULL;
            end else begin
              dst_d   = slot_add(head_q, count_q);
              src_d   = slot_dec(slot_add(head_q, count_q));
              left_d  = count_q - pos_cw;
              count_d = count_q + CW'(1);
              state_d = S_WALK;
            end
          end
          FN_REMOVE: begin
            if (!ok_pos) begin
              stat_d = ST_RANGE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = slot_add(head_q, pos_cw);
              dst_d   = slot_add(head_q, pos_cw);
              src_d   = slot_inc(slot_add(head_q, pos_cw));
              left_d  = count_q - pos_cw - CW'(1);
              count_d = count_q - CW'(1);
              state_d = S_GRAB;
            end
          end
          FN_READ: begin
            if (!ok_pos) begin
              stat_d = ST_RANGE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = slot_add(head_q, pos_cw);
              state_d = S_GRAB;
            end
          end
          FN_WRITE: begin
            if (!ok_pos) begin
              stat_d = ST_RANGE;
            end else begin
              wr_en   = 1'b1;
              wr_addr = slot_add(head_q, pos_cw);
            end
          end
          FN_ROT_FWD: begin
            if (count_q != '0) begin
              head_d = slot_inc(head_q);
            end
          end
          FN_ROT_BACK: begin
            if (count_q != '0) begin
              head_d = slot_dec(head_q);
            end
          end
          FN_CLEAR: begin
            count_d = '0;
            head_d  = '0;
          end
          default: begin
          end
        endcase
      end

      // Capture the item read at the requested position
      S_GRAB: begin
        result_d = rd_data;
        state_d  = (func_q == FN_REMOVE) ? S_WALK : S_DONE;
      end

      // Shift items one slot: read the source, write it back in the next cycle
      S_WALK: begin
        if (left_q != '0) begin
          rd_en      = 1'b1;
          rd_addr    = src_q;
          pend_d     = 1'b1;
          pend_dst_d = dst_q;
          left_d     = left_q - CW'(1);
          if (func_q == FN_INSERT) begin
            src_d = slot_dec(src_q);
            dst_d = slot_dec(dst_q);
          end else begin
            src_d = slot_inc(src_q);
            dst_d = slot_inc(dst_q);
          end
        end
        if (pend_q) begin
          wr_en   = 1'b1;
          wr_addr = pend_dst_q;
          wr_data = rd_data;
        end
        if (left_q == '0 && !pend_q) begin
          state_d = (func_q == FN_INSERT) ? S_FINAL : S_DONE;
        end
      end

      // Drop the new item into the opened slot
      S_FINAL: begin
        wr_en   = 1'b1;
        wr_addr = base_q;
        wr_data = item_q;
        state_d = S_DONE;
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          item_out_d  = result_q;
          status_d    = stat_q;
          length_d    = cnt_ext[LEN_W-1:0];
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      left_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      left_q      <= left_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q <= func_e'(func_i);
      pos_q  <= position_i;
      item_q <= item_in_i;
    end
    base_q     <= base_d;
    src_q      <= src_d;
    dst_q      <= dst_d;
    pend_dst_q <= pend_dst_d;
    result_q   <= result_d;
    stat_q     <= stat_d;
    item_out_q <= item_out_d;
    status_q   <= status_d;
    length_q   <= length_d;
  end

  assign out_valid_o = out_valid_q;
  assign item_out_o  = item_out_q;
  assign status_o    = status_q;
  assign length_o    = length_q;

  // Assertions
  a_walk_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && state_d != S_WALK) |-> (left_q == '0 && !pend_q))
    else $error("walk left with shifts outstanding");

  a_head_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> (head_q == $past(head_q) && count_q == $past(count_q)))
    else $error("list state changed while idle");

  a_pend_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ($past(state_q) == S_WALK && state_q == S_WALK))
    else $error("pending write-back outside the walk");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SETUP && func_q == FN_INSERT && full) |=> (count_q == CW'(CAPACITY)))
    else $error("insert into a full store changed the count");

endmodule
